/* rtl/csrc_pkg.sv */
// csrc_pkg: shared types and constants for the capacity split route cost decoder.
// Holds opcode codes, field widths, table entry layout and port packing offsets.
// No dependencies.
package csrc_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int NODE_W = 6;
    localparam int VAL_W  = 24;
    localparam int LOAD_W = 32;
    localparam int VEH_W  = 6;
    localparam int COST_W = 40;
    localparam int LEG_W  = VAL_W + 2;

    localparam logic [VEH_W-1:0]  VEH_MAX   = '1;
    localparam logic [COST_W-1:0] COST_MAX  = '1;
    localparam logic [LOAD_W-1:0] CAP_RESET = 32'h00FF_FFFF;

    // APB register map: one 32-bit register, word index in paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CAP_IDX = 1'b0;

    // stream packing, lowest bit first
    localparam int S_TDATA_W = 40;   // node_a, node_b, table_value, pad
    localparam int S_TUSER_W = 2;    // opcode
    localparam int M_TDATA_W = 56;   // visited_node, vehicle_number, total_cost, pad
    localparam int M_TUSER_W = 1;    // cost_saturated

    typedef enum logic [1:0] {
        OP_DEMAND = 2'd0,
        OP_DIST   = 2'd1,
        OP_VISIT  = 2'd2
    } op_t;

    // per-node row: demand, dist(depot -> node), dist(node -> depot)
    typedef struct packed {
        logic [VAL_W-1:0] demand;
        logic [VAL_W-1:0] from_depot;
        logic [VAL_W-1:0] to_depot;
    } node_entry_t;

endpackage

/* rtl/capacity_split_route_cost.sv */
// capacity_split_route_cost: giant-tour greedy split decoder, single module.
// Depends on csrc_pkg (widths, opcodes, node table entry layout).
//
// Usage: an APB port sets the per-vehicle load limit (byte address 0). Items arrive
// on the s_ stream: tuser carries the opcode, tdata the node indexes and table value,
// tlast marks the last node of a tour. Demand and distance loads write the
// tables and give no result; each visit gives one result on the m_ stream
// (tdata: node, vehicle number, total cost; tuser: saturation; tlast: final).
// A visit's result passes the table read registers, the stage 2 registers and the output register.
// Throughput: one item per cycle unless the receiver stalls; the distance matrix
// and the per-node table are each read once per visit at acceptance (node table
// on two read ports: the visited node and the previous one), so nothing repeats per item.
// Stages: table read, load/vehicle decision with leg sum, cost accumulate,
// output register. Each stage moves when the one after it is free, so the
// block keeps taking items while a result waits in the output register.
// Reset clears the tour state and returns the capacity to 2^24-1; the tables
// are not cleared and must be loaded before they are visited.
// When the receiver stalls, back pressure fills the stages and s_tready falls
// once all three hold visits.
module capacity_split_route_cost
    import csrc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // node_a[5:0], node_b[11:6], table_value[35:12]
    input  logic [S_TUSER_W-1:0]  s_tuser,  // opcode[1:0]
    input  logic                  s_tlast,  // tour_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // visited_node[5:0], vehicle_number[11:6],
                                            // total_cost[51:12]
    output logic [M_TUSER_W-1:0]  m_tuser,  // cost_saturated[0]
    output logic                  m_tlast   // final_visit
);

    localparam int NODE_DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int IW         = $clog2(NODE_DEPTH);
    localparam int NMEM_DEPTH = 1 << IW;
    localparam int DMEM_DEPTH = 1 << (2 * IW);
    localparam logic [NODE_W:0] NODE_LIM = (NODE_W + 1)'(NODE_DEPTH);
    localparam int COST_LSB = 2 * NODE_W;
    localparam int PAD_W    = M_TDATA_W - COST_LSB - COST_W;

    // ---------------- configuration ----------------
    logic [LOAD_W-1:0] cap_reg;
    logic              cap_wr;

    assign pready = 1'b1;
    assign cap_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAP_IDX);
    assign prdata = (paddr[2] == REG_CAP_IDX) ? cap_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cap_wr) begin
            cap_reg <= pwdata;
        end
    end

    // ---------------- handshake chain ----------------
    logic ready1, ready2, ready3;
    logic v1_reg, v2_reg, m_tvalid_reg;
    logic adv1, adv2, in_acc;

    assign ready3   = ~m_tvalid_reg | m_tready;
    assign ready2   = ~v2_reg | ready3;
    assign ready1   = ~v1_reg | ready2;
    assign s_tready = ready1;
    assign in_acc   = s_tvalid & ready1;
    assign adv1     = v1_reg & ready2;
    assign adv2     = v2_reg & ready3;

    // ---------------- input decode ----------------
    op_t               in_op;
    logic [NODE_W-1:0] in_a, in_b;
    logic [VAL_W-1:0]  in_val;
    logic              is_dem, is_dist, is_visit;
    logic              a_ok, b_ok;

    assign in_op  = op_t'(s_tuser);
    assign in_a   = s_tdata[NODE_W-1:0];
    assign in_b   = s_tdata[2*NODE_W-1:NODE_W];
    assign in_val = s_tdata[2*NODE_W+VAL_W-1:2*NODE_W];
    assign a_ok   = {1'b0, in_a} < NODE_LIM;
    assign b_ok   = {1'b0, in_b} < NODE_LIM;

    always_comb begin
        is_dem   = 1'b0;
        is_dist  = 1'b0;
        is_visit = 1'b0;
        unique case (in_op)
            OP_DEMAND: is_dem   = 1'b1;
            OP_DIST:   is_dist  = 1'b1;
            OP_VISIT:  is_visit = 1'b1;
            default: ;
        endcase
    end

    // node issued before this one, as seen at acceptance
    logic [NODE_W-1:0] prev_issue_reg;
    logic              prev_ok;

    assign prev_ok = {1'b0, prev_issue_reg} < NODE_LIM;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_issue_reg <= '0;
        end else if (in_acc && is_visit) begin
            prev_issue_reg <= s_tlast ? '0 : in_a;
        end
    end

    // ---------------- memories ----------------
    node_entry_t      node_mem [NMEM_DEPTH];
    logic [VAL_W-1:0] dist_mem [DMEM_DEPTH];

    logic             we_dem, we_from0, we_to0, we_dist;
    logic [IW-1:0]    node_wa, a_idx, b_idx, prev_idx;
    logic [2*IW-1:0]  dist_wa, dist_ra;

    assign a_idx    = in_a[IW-1:0];
    assign b_idx    = in_b[IW-1:0];
    assign prev_idx = prev_issue_reg[IW-1:0];
    assign we_dem   = is_dem & a_ok;
    assign we_dist  = is_dist & a_ok & b_ok;
    // depot row and depot column are mirrored into the node table
    assign we_from0 = we_dist & (in_a == '0);
    assign we_to0   = we_dist & (in_b == '0);
    assign node_wa  = (is_dist && in_a == '0) ? b_idx : a_idx;
    assign dist_wa  = {a_idx, b_idx};
    assign dist_ra  = {prev_idx, a_idx};

    node_entry_t      rd_a_reg, rd_p_reg;
    logic [VAL_W-1:0] rd_dist_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (we_dem) begin
                node_mem[node_wa].demand <= in_val;
            end
            if (we_from0) begin
                node_mem[node_wa].from_depot <= in_val;
            end
            if (we_to0) begin
                node_mem[node_wa].to_depot <= in_val;
            end
            if (we_dist) begin
                dist_mem[dist_wa] <= in_val;
            end
            if (is_visit) begin
                rd_a_reg    <= node_mem[a_idx];
                rd_p_reg    <= node_mem[prev_idx];
                rd_dist_reg <= dist_mem[dist_ra];
            end
        end
    end

    // ---------------- stage 1: load / vehicle decision ----------------
    logic [NODE_W-1:0] node1_reg;
    logic              last1_reg, aok1_reg, pok1_reg;
    logic [LOAD_W-1:0] load_reg, load_next;
    logic [VEH_W-1:0]  veh_reg, veh_next, veh_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_acc && is_visit) begin
            v1_reg <= 1'b1;
        end else if (ready2) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && is_visit) begin
            node1_reg <= in_a;
            last1_reg <= s_tlast;
            aok1_reg  <= a_ok;
            pok1_reg  <= prev_ok;
        end
    end

    logic [VAL_W-1:0]  dem1, d0a, da0, dp0, dpa;
    logic [LOAD_W:0]   load_sum;
    logic              fits;
    logic [LEG_W-2:0]  leg_move;
    logic [LEG_W-1:0]  leg1;
    logic [LOAD_W-1:0] load_new;

    always_comb begin
        dem1     = aok1_reg ? rd_a_reg.demand : '0;
        d0a      = aok1_reg ? rd_a_reg.from_depot : '0;
        da0      = aok1_reg ? rd_a_reg.to_depot : '0;
        dp0      = pok1_reg ? rd_p_reg.to_depot : '0;
        dpa      = (aok1_reg && pok1_reg) ? rd_dist_reg : '0;
        load_sum = {1'b0, load_reg} + (LOAD_W + 1)'(dem1);
        fits     = load_sum <= {1'b0, cap_reg};
        load_new = fits ? load_sum[LOAD_W-1:0] : LOAD_W'(dem1);
        if (fits) begin
            veh_new = veh_reg;
        end else if (veh_reg == VEH_MAX) begin
            veh_new = veh_reg;
        end else begin
            veh_new = veh_reg + VEH_W'(1);
        end
        // detour through the depot when a new vehicle opens
        leg_move  = fits ? (LEG_W - 1)'(dpa) : (LEG_W - 1)'(dp0) + (LEG_W - 1)'(d0a);
        leg1      = LEG_W'(leg_move) + LEG_W'(last1_reg ? da0 : '0);
        load_next = last1_reg ? '0 : load_new;
        veh_next  = last1_reg ? '0 : veh_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
            veh_reg  <= '0;
        end else if (adv1) begin
            load_reg <= load_next;
            veh_reg  <= veh_next;
        end
    end

    // ---------------- stage 2: cost accumulate ----------------
    logic [NODE_W-1:0] node2_reg;
    logic [VEH_W-1:0]  veh2_reg;
    logic              last2_reg;
    logic [LEG_W-1:0]  leg2_reg;
    logic [COST_W-1:0] cost_reg, cost_next, cost_new;
    logic              sat_reg, sat_next, sat_new;
    logic [COST_W:0]   cost_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv1) begin
            v2_reg <= 1'b1;
        end else if (ready3) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            node2_reg <= node1_reg;
            veh2_reg  <= veh_new;
            last2_reg <= last1_reg;
            leg2_reg  <= leg1;
        end
    end

    always_comb begin
        // cost stays at or below max and a leg is short, so bit 40 flags overflow
        cost_sum  = {1'b0, cost_reg} + (COST_W + 1)'(leg2_reg);
        cost_new  = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
        sat_new   = sat_reg | cost_sum[COST_W];
        cost_next = last2_reg ? '0 : cost_new;
        sat_next  = last2_reg ? 1'b0 : sat_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg <= '0;
            sat_reg  <= 1'b0;
        end else if (adv2) begin
            cost_reg <= cost_next;
            sat_reg  <= sat_next;
        end
    end

    // ---------------- output register ----------------
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv2) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, (last2_reg ? cost_new : '0), veh2_reg, node2_reg};
            m_tuser_reg <= M_TUSER_W'(sat_new);
            m_tlast_reg <= last2_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    a_sat_pins_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (cost_reg == COST_MAX))
        else $error("saturation flag set with cost below max");

    a_tour_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && last1_reg) |=> (load_reg == '0 && veh_reg == '0))
        else $error("route state not cleared after final visit");

    a_cost_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tlast_reg) |-> (m_tdata_reg[COST_LSB+COST_W-1:COST_LSB] == '0))
        else $error("nonzero total cost on a non-final result");

    a_prev_to_depot: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && is_visit && s_tlast) |=> (prev_issue_reg == '0))
        else $error("previous node not returned to depot at tour end");

endmodule
